@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; compiled out with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SIFT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SIFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`else
`define SIFT_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define SIFT_ASSERT(lbl, prop, msg)
`endif

`endif

@@ rtl/core/sift_pkg.sv @@
// ----------------------------------------------------------------------------
// sift_pkg
// Shared constants and codes of the unique-key table.
// ----------------------------------------------------------------------------
`default_nettype none

package sift_pkg;

  localparam int CAPACITY = 16;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_READ   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_INSERTED = 3'd1,
    ST_PRESENT  = 3'd2,
    ST_FULL     = 3'd3,
    ST_READ_OK  = 3'd4,
    ST_BAD_IDX  = 3'd5,
    ST_CLEARED  = 3'd6
  } status_e;

endpackage

`default_nettype wire

@@ rtl/core/sift_mem.sv @@
// ----------------------------------------------------------------------------
// sift_mem
// Single-port-write, single-port-read entry store with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sift_mem #(
  parameter int DEPTH = sift_pkg::CAPACITY,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [31:0]   wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [31:0]   rdata_o
);

  logic [31:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/core/search_insert_front_table.sv @@
// ----------------------------------------------------------------------------
// search_insert_front_table
// Table of unique signed keys with append, search-and-insert-at-front,
// read and clear requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in channel (req_type_i, value_i, index_i) under
//   in_valid_i / in_ready_o; each gives one result transaction on the out
//   channel (status_o, read_value_o, entry_count_o, all_positive_o) under
//   out_valid_o / out_ready_i.
//   One request is in flight at a time. Clear and append go from acceptance
//   straight to the done state, read passes through a read state first, and
//   search_insert scans a table of N entries (N >= 1): the entries are
//   compared one per cycle through the single read port of the entry memory,
//   a hit ends the scan, and a miss writes the key at the new head unless the
//   table is full. An empty table inserts without a scan. Insert at front
//   moves a head pointer, so no entry is copied.
//   A finished result sits in an output register; the next request is taken
//   in the cycle after it is loaded there and while it waits. If the
//   receiver stalls, a further result is held inside until the output
//   register is free.
//   Reset empties the table at once (count and head pointer cleared); the
//   entry memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module search_insert_front_table #(
  parameter int CAPACITY = sift_pkg::CAPACITY
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         req_type_i,
  input  wire logic signed [31:0] value_i,
  input  wire logic [3:0]         index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [2:0]              status_o,
  output logic signed [31:0]      read_value_o,
  output logic [4:0]              entry_count_o,
  output logic                    all_positive_o
);

`include "assert_macros.svh"

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = (CW > 4) ? CW : 4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DONE
  } state_e;

  state_e               state_q;
  logic [CW-1:0]        count_q;
  logic [AW-1:0]        base_q;
  logic                 any_nonpos_q;
  logic [31:0]          key_q;
  logic [CW-1:0]        ptr_q;
  logic                 cmp_v_q;
  logic                 cmp_last_q;
  sift_pkg::status_e    res_status_q;
  logic [31:0]          res_rd_q;
  logic                 out_valid_q;
  logic [2:0]           out_status_q;
  logic [31:0]          out_rd_q;
  logic [4:0]           out_count_q;
  logic                 out_pos_q;

  logic                 in_acc;
  logic                 full;
  logic                 match;
  logic                 idx_ok;
  logic [AW-1:0]        base_m1;
  sift_pkg::req_e       req;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [31:0]          mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [31:0]          mem_rdata;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + (AW+1)'(off);
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic nonpos(input logic [31:0] v);
    return v[31] || (v == 32'd0);
  endfunction

  assign req        = sift_pkg::req_e'(req_type_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign full       = (count_q == CW'(CAPACITY));
  assign match      = cmp_v_q && (mem_rdata == key_q);
  assign idx_ok     = IW'(index_i) < IW'(count_q);
  assign base_m1    = (base_q == '0) ? AW'(CAPACITY - 1) : base_q - AW'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = phys(base_q, count_q);
    mem_wdata = value_i;
    mem_raddr = phys(base_q, ptr_q);
    if (in_acc) begin
      case (req)
        sift_pkg::REQ_APPEND: begin
          mem_we = !full;
        end
        sift_pkg::REQ_SEARCH: begin
          mem_we    = (count_q == '0);
          mem_waddr = base_m1;
        end
        sift_pkg::REQ_READ: begin
          mem_raddr = phys(base_q, CW'(index_i));
        end
        default: begin
        end
      endcase
    end else if (state_q == S_SCAN && cmp_v_q && cmp_last_q && !match && !full) begin
      mem_we    = 1'b1;
      mem_waddr = base_m1;
      mem_wdata = key_q;
    end
  end

  sift_mem #(
    .DEPTH(CAPACITY)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      base_q       <= '0;
      any_nonpos_q <= 1'b0;
      key_q        <= '0;
      ptr_q        <= '0;
      cmp_v_q      <= 1'b0;
      cmp_last_q   <= 1'b0;
      res_status_q <= sift_pkg::ST_APPENDED;
      res_rd_q     <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_rd_q     <= '0;
      out_count_q  <= '0;
      out_pos_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            res_rd_q <= '0;
            key_q    <= value_i;
            ptr_q    <= '0;
            cmp_v_q  <= 1'b0;
            case (req)
              sift_pkg::REQ_CLEAR: begin
                count_q      <= '0;
                any_nonpos_q <= 1'b0;
                res_status_q <= sift_pkg::ST_CLEARED;
                state_q      <= S_DONE;
              end
              sift_pkg::REQ_APPEND: begin
                state_q <= S_DONE;
                if (full) begin
                  res_status_q <= sift_pkg::ST_FULL;
                end else begin
                  count_q      <= count_q + CW'(1);
                  any_nonpos_q <= any_nonpos_q || nonpos(value_i);
                  res_status_q <= sift_pkg::ST_APPENDED;
                end
              end
              sift_pkg::REQ_SEARCH: begin
                if (count_q == '0) begin
                  base_q       <= base_m1;
                  count_q      <= CW'(1);
                  any_nonpos_q <= nonpos(value_i);
                  res_status_q <= sift_pkg::ST_INSERTED;
                  state_q      <= S_DONE;
                end else begin
                  state_q <= S_SCAN;
                end
              end
              sift_pkg::REQ_READ: begin
                if (idx_ok) begin
                  res_status_q <= sift_pkg::ST_READ_OK;
                  state_q      <= S_READ;
                end else begin
                  res_status_q <= sift_pkg::ST_BAD_IDX;
                  state_q      <= S_DONE;
                end
              end
              default: begin
                state_q <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (match) begin
            cmp_v_q      <= 1'b0;
            res_status_q <= sift_pkg::ST_PRESENT;
            state_q      <= S_DONE;
          end else if (cmp_v_q && cmp_last_q) begin
            cmp_v_q <= 1'b0;
            state_q <= S_DONE;
            if (full) begin
              res_status_q <= sift_pkg::ST_FULL;
            end else begin
              base_q       <= base_m1;
              count_q      <= count_q + CW'(1);
              any_nonpos_q <= any_nonpos_q || nonpos(key_q);
              res_status_q <= sift_pkg::ST_INSERTED;
            end
          end else if (ptr_q < count_q) begin
            cmp_v_q    <= 1'b1;
            cmp_last_q <= (ptr_q == count_q - CW'(1));
            ptr_q      <= ptr_q + CW'(1);
          end else begin
            cmp_v_q <= 1'b0;
          end
        end
        S_READ: begin
          res_rd_q <= mem_rdata;
          state_q  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_rd_q     <= res_rd_q;
            out_count_q  <= 5'(count_q);
            out_pos_q    <= !any_nonpos_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign read_value_o   = out_rd_q;
  assign entry_count_o  = out_count_q;
  assign all_positive_o = out_pos_q;

  `SIFT_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "entry count exceeds capacity")
  `SIFT_ASSERT(a_write_not_full, mem_we |-> !full, "entry write into a full table")
  `SIFT_ASSERT(a_empty_positive, (count_q == '0) |-> !any_nonpos_q, "empty table non-positive")
  `SIFT_ASSERT_CLK(a_cmp_in_scan, clk_i, rst_ni, cmp_v_q |-> (state_q == S_SCAN), "compare outside scan")

endmodule

`default_nettype wire

@@ tb/search_insert_front_table_tb.sv @@
// ----------------------------------------------------------------------------
// search_insert_front_table_tb
// Self-checking bench for the unique-key table. A directed opening covers the
// empty table, the extreme keys, duplicate keys and clearing. Random request
// sequences then fill the table past capacity, hit and miss on keys and read
// every position. Both channels idle and stall at random, and each result is
// compared with a cycle-free predictor of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module search_insert_front_table_tb;

  localparam int DEPTH        = sift_pkg::CAPACITY;
  localparam int ITEM_TARGET  = 1950;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SHOWN_ERRORS = 10;

  typedef struct {
    sift_pkg::req_e     kind;
    logic signed [31:0] value;
    logic [3:0]         index;
  } request_t;

  typedef struct {
    sift_pkg::status_e  status;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
    logic               all_positive;
  } result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready_o;
  logic [1:0]         req_type;
  logic signed [31:0] value;
  logic [3:0]         index;
  logic               out_valid_o;
  logic               out_ready;
  logic [2:0]         status_o;
  logic signed [31:0] read_value_o;
  logic [4:0]         entry_count_o;
  logic               all_positive_o;

  request_t pending_requests_q[$];
  result_t  expected_results_q[$];
  request_t driven_request;
  result_t  oldest_result;

  logic signed [31:0] table_entries [DEPTH];
  int                 table_count;

  int gap_left;
  int quiet_gap_left;
  int stall_left;
  int quiet_stall_left;
  int mismatch_count;
  int cycle_count;

  search_insert_front_table dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type),
    .value_i        (value),
    .index_i        (index),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .status_o       (status_o),
    .read_value_o   (read_value_o),
    .entry_count_o  (entry_count_o),
    .all_positive_o (all_positive_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic result_t apply_table_request(request_t rq);
    result_t res;
    bit      hit;
    hit              = 1'b0;
    res.read_value   = '0;
    res.status       = sift_pkg::ST_CLEARED;
    case (rq.kind)
      sift_pkg::REQ_CLEAR: begin
        table_count = 0;
        res.status  = sift_pkg::ST_CLEARED;
      end
      sift_pkg::REQ_APPEND: begin
        if (table_count >= DEPTH) begin
          res.status = sift_pkg::ST_FULL;
        end else begin
          table_entries[table_count] = rq.value;
          table_count++;
          res.status = sift_pkg::ST_APPENDED;
        end
      end
      sift_pkg::REQ_SEARCH: begin
        for (int i = 0; i < table_count; i++) begin
          if (table_entries[i] == rq.value) hit = 1'b1;
        end
        if (hit) begin
          res.status = sift_pkg::ST_PRESENT;
        end else if (table_count >= DEPTH) begin
          res.status = sift_pkg::ST_FULL;
        end else begin
          for (int i = table_count; i > 0; i--) table_entries[i] = table_entries[i - 1];
          table_entries[0] = rq.value;
          table_count++;
          res.status = sift_pkg::ST_INSERTED;
        end
      end
      default: begin
        if (int'(rq.index) < table_count) begin
          res.read_value = table_entries[rq.index];
          res.status     = sift_pkg::ST_READ_OK;
        end else begin
          res.status = sift_pkg::ST_BAD_IDX;
        end
      end
    endcase
    res.entry_count  = table_count[4:0];
    res.all_positive = 1'b1;
    for (int i = 0; i < table_count; i++) begin
      if (table_entries[i] <= 0) res.all_positive = 1'b0;
    end
    return res;
  endfunction

  function automatic int idle_gap();
    int r;
    if (quiet_gap_left > 0) begin
      quiet_gap_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet_gap_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int stall_gap();
    int r;
    if (quiet_stall_left > 0) begin
      quiet_stall_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      quiet_stall_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [3:0] pick_pos();
    return 4'($urandom_range(0, 15));
  endfunction

  function automatic logic signed [31:0] pick_key(bit positive_only);
    logic [31:0] raw;
    int          r;
    r   = $urandom_range(0, 9);
    raw = $urandom();
    if (positive_only) begin
      case (r)
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sd1;
        2, 3, 4: return $urandom_range(1, 40);
        default: begin
          raw[31] = 1'b0;
          if (raw == '0) raw = 32'd1;
          return raw;
        end
      endcase
    end
    case (r)
      0:       return 32'sh8000_0000;
      1:       return 32'sd0;
      2:       return -32'sd1;
      3:       return 32'sh7FFF_FFFF;
      4, 5, 6: return $signed($urandom_range(0, 40)) - 32'sd20;
      default: return raw;
    endcase
  endfunction

  task automatic queue_request(sift_pkg::req_e kind, logic signed [31:0] key, logic [3:0] pos);
    request_t rq;
    rq.kind  = kind;
    rq.value = key;
    rq.index = pos;
    pending_requests_q.push_back(rq);
  endtask

  // Driver: hold the transaction until accepted, predict at acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      req_type <= sift_pkg::REQ_CLEAR;
      value    <= '0;
      index    <= '0;
      gap_left  = 0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_results_q.push_back(apply_table_request(driven_request));
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left > 0 || pending_requests_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          driven_request = pending_requests_q.pop_front();
          req_type <= driven_request.kind;
          value    <= driven_request.value;
          index    <= driven_request.index;
          in_valid <= 1'b1;
          gap_left  = idle_gap();
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_results_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_ERRORS) begin
            $display("unexpected result: status %0d read_value %0d count %0d all_positive %0b",
                     status_o, read_value_o, entry_count_o, all_positive_o);
          end
        end else begin
          oldest_result = expected_results_q.pop_front();
          if (status_o !== oldest_result.status ||
              read_value_o !== oldest_result.read_value ||
              entry_count_o !== oldest_result.entry_count ||
              all_positive_o !== oldest_result.all_positive) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_ERRORS) begin
              $display("mismatch: status exp %0d got %0d, read_value exp %0d got %0d,",
                       oldest_result.status, status_o, oldest_result.read_value,
                       read_value_o);
              $display("          count exp %0d got %0d, all_positive exp %0b got %0b",
                       oldest_result.entry_count, entry_count_o,
                       oldest_result.all_positive, all_positive_o);
            end
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left = stall_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic signed [31:0] key_pool [8];
    bit                 positive_only;
    int                 fill_len;
    int                 op_len;
    int                 r;
    sift_pkg::req_e     kind;

    rst_ni           = 1'b0;
    mismatch_count   = 0;
    cycle_count      = 0;
    table_count      = 0;
    quiet_gap_left   = 0;
    quiet_stall_left = 0;
    for (int i = 0; i < DEPTH; i++) table_entries[i] = '0;

    // Directed opening: empty table, extreme keys, duplicates, clearing.
    queue_request(sift_pkg::REQ_READ,   32'sd0,           4'd0);
    queue_request(sift_pkg::REQ_SEARCH, 32'sh7FFF_FFFF,   4'd0);
    queue_request(sift_pkg::REQ_SEARCH, 32'sh7FFF_FFFF,   4'd15);
    queue_request(sift_pkg::REQ_APPEND, 32'sh8000_0000,   4'd0);
    queue_request(sift_pkg::REQ_APPEND, 32'sd0,           4'd0);
    queue_request(sift_pkg::REQ_SEARCH, 32'sd1,           4'd0);
    queue_request(sift_pkg::REQ_SEARCH, 32'sh8000_0000,   4'd0);
    queue_request(sift_pkg::REQ_READ,   32'sd0,           4'd0);
    queue_request(sift_pkg::REQ_READ,   32'sd0,           4'd3);
    queue_request(sift_pkg::REQ_READ,   32'sd0,           4'd4);
    queue_request(sift_pkg::REQ_READ,   -32'sd1,          4'd15);
    queue_request(sift_pkg::REQ_CLEAR,  -32'sd1,          4'd15);
    queue_request(sift_pkg::REQ_READ,   32'sd0,           4'd0);
    queue_request(sift_pkg::REQ_SEARCH, 32'sh8000_0000,   4'd0);
    queue_request(sift_pkg::REQ_APPEND, -32'sd1,          4'd0);
    queue_request(sift_pkg::REQ_READ,   32'sd0,           4'd1);
    queue_request(sift_pkg::REQ_CLEAR,  32'sd0,           4'd0);
    queue_request(sift_pkg::REQ_SEARCH, 32'sd5,           4'd0);
    queue_request(sift_pkg::REQ_APPEND, 32'sd5,           4'd0);
    queue_request(sift_pkg::REQ_SEARCH, 32'sd5,           4'd0);
    queue_request(sift_pkg::REQ_READ,   32'sd0,           4'd1);

    while (pending_requests_q.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 99) < 75) begin
        positive_only = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < 8; i++) key_pool[i] = pick_key(positive_only);
        if ($urandom_range(0, 4) != 0) begin
          queue_request(sift_pkg::REQ_CLEAR, $urandom(), pick_pos());
        end
        fill_len = $urandom_range(0, 20);
        for (int i = 0; i < fill_len; i++) begin
          kind = $urandom_range(0, 1) ? sift_pkg::REQ_APPEND : sift_pkg::REQ_SEARCH;
          if ($urandom_range(0, 9) < 7) begin
            queue_request(kind, key_pool[$urandom_range(0, 7)], pick_pos());
          end else begin
            queue_request(kind, pick_key(positive_only), pick_pos());
          end
        end
        op_len = $urandom_range(2, 12);
        for (int i = 0; i < op_len; i++) begin
          r = $urandom_range(0, 99);
          if (r < 40) begin
            queue_request(sift_pkg::REQ_READ, $urandom(), pick_pos());
          end else if (r < 75) begin
            queue_request(sift_pkg::REQ_SEARCH, key_pool[$urandom_range(0, 7)], pick_pos());
          end else if (r < 85) begin
            queue_request(sift_pkg::REQ_APPEND, key_pool[$urandom_range(0, 7)], pick_pos());
          end else begin
            queue_request(sift_pkg::REQ_SEARCH, pick_key(positive_only), pick_pos());
          end
        end
      end else begin
        op_len = $urandom_range(1, 6);
        for (int i = 0; i < op_len; i++) begin
          queue_request(sift_pkg::req_e'($urandom_range(0, 3)), $urandom(), pick_pos());
        end
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests_q.size() != 0 || in_valid) @(posedge clk_i);
    while (expected_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/sift_pkg.sv
rtl/core/sift_mem.sv
rtl/core/search_insert_front_table.sv
tb/search_insert_front_table_tb.sv
